// ----- hdl/delimited_field_splitter_top_macros.svh -----
// ----------------------------------------------------------------------------
// Delimited field splitter assertion macros
// Short forms for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FIELD_SPLITTER_TOP_MACROS_SVH
`define DELIMITED_FIELD_SPLITTER_TOP_MACROS_SVH

// Same-cycle implication.
`define DFS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dfs_pkg.sv -----
// ----------------------------------------------------------------------------
// Delimited field splitter package
// Shared types, register codes and reset values.
// ----------------------------------------------------------------------------
package dfs_pkg;

    localparam int MAX_FIELDS_DEFAULT = 1024;
    localparam int FIELD_INDEX_W      = 10;
    localparam int INDEX_CAP          = 1023;
    localparam int CFG_INDEX_W        = 8;
    localparam int CFG_DATA_W         = 64;
    localparam int S_TDATA_W          = 8;
    localparam int M_TDATA_W          = 24;
    localparam int M_TUSER_W          = 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_QUOTE_CHARS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HARD_SET    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLANK_SET   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_EN   = 8'd3;

    localparam logic [15:0] QUOTE_CHARS_RESET = 16'h2227;
    localparam logic [31:0] HARD_SET_RESET    = 32'h0000_002C;
    localparam logic [63:0] BLANK_SET_RESET   = 64'h0000_0C0A_0D0B_0920;
    localparam logic        ESCAPE_EN_RESET   = 1'b0;

    typedef struct packed {
        logic [15:0] quote_chars;
        logic [31:0] hard_set;
        logic [63:0] blank_set;
        logic        escape_en;
    } dfs_cfg_t;

    typedef struct packed {
        logic blank;
        logic hard;
        logic quote;
    } dfs_class_t;

    typedef struct packed {
        logic [7:0]               out_byte;
        logic                     byte_valid;
        logic                     field_end;
        logic [FIELD_INDEX_W-1:0] field_index;
        logic                     line_done;
        logic                     unterminated_quote;
        logic                     missing_delimiter;
        logic                     last;
    } dfs_result_t;

    typedef struct packed {
        logic [1:0]  count;
        dfs_result_t first;
        dfs_result_t second;
    } dfs_push_t;

endpackage

// ----- hdl/dfs_classify.sv -----
// ----------------------------------------------------------------------------
// Delimited field splitter byte classifier
// Compares one byte against the quote, hard and soft separator slots.
// ----------------------------------------------------------------------------
module dfs_classify (
    input  logic [7:0]        data_byte,
    input  dfs_pkg::dfs_cfg_t cfg,
    output dfs_pkg::dfs_class_t cls
);

    always_comb begin
        cls = '0;
        for (int i = 0; i < 2; i++) begin
            if (cfg.quote_chars[8*i +: 8] != 8'd0 && cfg.quote_chars[8*i +: 8] == data_byte) begin
                cls.quote = 1'b1;
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (cfg.hard_set[8*i +: 8] != 8'd0 && cfg.hard_set[8*i +: 8] == data_byte) begin
                cls.hard = 1'b1;
            end
        end
        for (int i = 0; i < 8; i++) begin
            if (cfg.blank_set[8*i +: 8] != 8'd0 && cfg.blank_set[8*i +: 8] == data_byte) begin
                cls.blank = 1'b1;
            end
        end
    end

endmodule

// ----- hdl/dfs_parser.sv -----
// ----------------------------------------------------------------------------
// Delimited field splitter parser
// Input register, scan state and result generation, one item per cycle while room is set.
// ----------------------------------------------------------------------------
module dfs_parser #(
    parameter int MAX_FIELDS = dfs_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_byte,
    input  logic              s_eol,
    input  dfs_pkg::dfs_cfg_t cfg,
    input  logic              room,
    output dfs_pkg::dfs_push_t push
);

    localparam int CW = $clog2(MAX_FIELDS);
    localparam int XW = (CW > dfs_pkg::FIELD_INDEX_W) ? CW : dfs_pkg::FIELD_INDEX_W;

    localparam logic [2:0] M_SKIP       = 3'd0;
    localparam logic [2:0] M_AFTER_SOFT = 3'd1;
    localparam logic [2:0] M_PLAIN      = 3'd2;
    localparam logic [2:0] M_QUOTED     = 3'd3;
    localparam logic [2:0] M_CLOSED     = 3'd4;

    logic          item_valid_reg;
    logic [7:0]    item_byte_reg;
    logic          item_eol_reg;
    logic [2:0]    mode_reg, mode_next;
    logic [7:0]    quote_reg, quote_next;
    logic [CW-1:0] count_reg, count_next;
    logic          fire;
    logic [1:0]    n_res;
    dfs_pkg::dfs_result_t r0, r1;
    dfs_pkg::dfs_class_t  cls;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c < CW'(MAX_FIELDS - 1)) ? c + CW'(1) : c;
    endfunction

    function automatic logic [dfs_pkg::FIELD_INDEX_W-1:0] cap(input logic [CW-1:0] c);
        logic [XW-1:0] ext;
        ext = XW'(c);
        return (ext > XW'(dfs_pkg::INDEX_CAP)) ? dfs_pkg::FIELD_INDEX_W'(dfs_pkg::INDEX_CAP)
                                               : ext[dfs_pkg::FIELD_INDEX_W-1:0];
    endfunction

    dfs_classify u_classify (
        .data_byte (item_byte_reg),
        .cfg       (cfg),
        .cls       (cls)
    );

    assign fire     = item_valid_reg && room;
    assign s_tready = !item_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            mode_reg       <= M_SKIP;
            quote_reg      <= 8'd0;
            count_reg      <= '0;
        end else begin
            item_valid_reg <= (s_tvalid && s_tready) || (item_valid_reg && !fire);
            if (fire) begin
                mode_reg  <= mode_next;
                quote_reg <= quote_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_byte_reg <= s_byte;
            item_eol_reg  <= s_eol;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        count_next = count_reg;
        n_res      = 2'd0;
        r0         = '0;
        r1         = '0;
        r0.field_index = cap(count_reg);
        r1.field_index = cap(sat_inc(count_reg));

        if (item_eol_reg) begin
            n_res        = 2'd1;
            r0.line_done = 1'b1;
            if (mode_reg == M_PLAIN || mode_reg == M_CLOSED) begin
                r0.field_end = 1'b1;
            end else if (mode_reg == M_QUOTED) begin
                r0.field_end          = 1'b1;
                r0.unterminated_quote = 1'b1;
            end
            mode_next  = M_SKIP;
            quote_next = 8'd0;
            count_next = '0;
        end else begin
            unique case (mode_reg)
                M_AFTER_SOFT: begin
                    if (cls.blank) begin
                        mode_next = M_AFTER_SOFT;
                    end else if (cls.hard) begin
                        mode_next = M_SKIP;
                    end else if (cls.quote) begin
                        quote_next = item_byte_reg;
                        mode_next  = M_QUOTED;
                    end else begin
                        n_res         = 2'd1;
                        r0.out_byte   = item_byte_reg;
                        r0.byte_valid = 1'b1;
                        mode_next     = M_PLAIN;
                    end
                end
                M_PLAIN: begin
                    n_res = 2'd1;
                    if (cls.blank || cls.hard) begin
                        r0.field_end = 1'b1;
                        count_next   = sat_inc(count_reg);
                        mode_next    = cls.blank ? M_AFTER_SOFT : M_SKIP;
                    end else begin
                        r0.out_byte   = item_byte_reg;
                        r0.byte_valid = 1'b1;
                    end
                end
                M_QUOTED: begin
                    if (item_byte_reg == quote_reg) begin
                        mode_next = M_CLOSED;
                    end else begin
                        n_res         = 2'd1;
                        r0.out_byte   = item_byte_reg;
                        r0.byte_valid = 1'b1;
                    end
                end
                M_CLOSED: begin
                    n_res = 2'd1;
                    if (cfg.escape_en && item_byte_reg == quote_reg) begin
                        r0.out_byte   = item_byte_reg;
                        r0.byte_valid = 1'b1;
                        mode_next     = M_QUOTED;
                    end else if (cls.blank || cls.hard) begin
                        r0.field_end = 1'b1;
                        count_next   = sat_inc(count_reg);
                        mode_next    = cls.blank ? M_AFTER_SOFT : M_SKIP;
                    end else begin
                        // The flagged field end, then this byte opens the next field.
                        r0.field_end         = 1'b1;
                        r0.missing_delimiter = 1'b1;
                        count_next           = sat_inc(count_reg);
                        if (cls.quote) begin
                            quote_next = item_byte_reg;
                            mode_next  = M_QUOTED;
                        end else if (cls.hard) begin
                            n_res        = 2'd2;
                            r1.field_end = 1'b1;
                            count_next   = sat_inc(sat_inc(count_reg));
                            mode_next    = M_SKIP;
                        end else begin
                            n_res         = 2'd2;
                            r1.out_byte   = item_byte_reg;
                            r1.byte_valid = 1'b1;
                            mode_next     = M_PLAIN;
                        end
                    end
                end
                default: begin
                    // Line start or after a hard separator; unused codes act the same.
                    mode_next = M_SKIP;
                    if (!cls.blank) begin
                        if (cls.quote) begin
                            quote_next = item_byte_reg;
                            mode_next  = M_QUOTED;
                        end else if (cls.hard) begin
                            n_res        = 2'd1;
                            r0.field_end = 1'b1;
                            count_next   = sat_inc(count_reg);
                        end else begin
                            n_res         = 2'd1;
                            r0.out_byte   = item_byte_reg;
                            r0.byte_valid = 1'b1;
                            mode_next     = M_PLAIN;
                        end
                    end
                end
            endcase
        end

        r0.last = (n_res == 2'd1);
        r1.last = 1'b1;

        push.count  = fire ? n_res : 2'd0;
        push.first  = r0;
        push.second = r1;
    end

endmodule

// ----- hdl/dfs_out_queue.sv -----
// ----------------------------------------------------------------------------
// Delimited field splitter result queue
// Four-entry shifting queue that takes up to two results per cycle.
// ----------------------------------------------------------------------------
module dfs_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dfs_pkg::dfs_push_t   push,
    output logic                 room,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output dfs_pkg::dfs_result_t head
);

    localparam int DEPTH = 4;

    dfs_pkg::dfs_result_t q_reg  [DEPTH];
    dfs_pkg::dfs_result_t q_next [DEPTH];
    logic [2:0] count_reg, count_next;
    logic [2:0] base;
    logic       pop;

    assign m_tvalid = (count_reg != 3'd0);
    assign head     = q_reg[0];
    assign pop      = m_tvalid && m_tready;
    // Room for a worst-case item is judged on the registered fill only.
    assign room     = (count_reg <= 3'(DEPTH - 2));

    always_comb begin
        base       = count_reg - {2'd0, pop};
        count_next = base + {1'b0, push.count};
        for (int i = 0; i < DEPTH; i++) begin
            if (pop && i < DEPTH - 1) begin
                q_next[i] = q_reg[i + 1];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (push.count != 2'd0 && base == 3'(i)) begin
                q_next[i] = push.first;
            end
            if (push.count == 2'd2 && base + 3'd1 == 3'(i)) begin
                q_next[i] = push.second;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

// ----- hdl/delimited_field_splitter_top.sv -----
// ----------------------------------------------------------------------------
// Delimited field splitter top level
// Splits a byte stream of text lines into field bytes and field ends.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_*       in         one line byte (tdata[7:0]) or end of line (tlast)
//  m_*       out        field byte, field end or line done, with field index
//  cfg_*     in         register writes: index and 64-bit data
//
// One input item is taken per cycle while the result queue has room; an item
// produces zero, one or two results, and the result queue drains one result
// per cycle while m_tready is high. A result passes through the input register,
// then the result queue. aresetn is synchronous and active low; it restores the
// register reset values and the line-start scan state.
// The input stalls only while the result queue holds more than two results.
module delimited_field_splitter_top #(
    parameter int MAX_FIELDS = dfs_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dfs_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // end_of_line
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dfs_pkg::M_TDATA_W-1:0]     m_tdata,   // [7:0] out_byte, [17:8] field_index
    output logic [dfs_pkg::M_TUSER_W-1:0]     m_tuser,   // byte_valid, field_end, line_done,
                                                         // unterminated_quote, missing_delimiter
    output logic                              m_tlast,   // last
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    dfs_pkg::dfs_cfg_t    cfg_reg;
    dfs_pkg::dfs_push_t   push;
    dfs_pkg::dfs_result_t head;
    logic                 room;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quote_chars <= dfs_pkg::QUOTE_CHARS_RESET;
            cfg_reg.hard_set    <= dfs_pkg::HARD_SET_RESET;
            cfg_reg.blank_set   <= dfs_pkg::BLANK_SET_RESET;
            cfg_reg.escape_en   <= dfs_pkg::ESCAPE_EN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dfs_pkg::REG_QUOTE_CHARS: cfg_reg.quote_chars <= cfg_data[15:0];
                dfs_pkg::REG_HARD_SET:    cfg_reg.hard_set    <= cfg_data[31:0];
                dfs_pkg::REG_BLANK_SET:   cfg_reg.blank_set   <= cfg_data;
                dfs_pkg::REG_ESCAPE_EN:   cfg_reg.escape_en   <= cfg_data[0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    dfs_parser #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata[7:0]),
        .s_eol    (s_tlast),
        .cfg      (cfg_reg),
        .room     (room),
        .push     (push)
    );

    dfs_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = {6'd0, head.field_index, head.out_byte};
    assign m_tuser = {head.missing_delimiter, head.unterminated_quote, head.line_done,
                      head.field_end, head.byte_valid};
    assign m_tlast = head.last;

endmodule

// ----- hdl/dfs_checker.sv -----
// ----------------------------------------------------------------------------
// Delimited field splitter port checker
// Watches the top-level ports for result stability and flag consistency.
// ----------------------------------------------------------------------------
`include "delimited_field_splitter_top_macros.svh"

module dfs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dfs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [dfs_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);

    // A stalled result keeps its contents.
    `DFS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")
    // A result never carries both a content byte and a field end.
    `DFS_ASSERT_IMP(a_kind, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]), "byte and field end together")
    // The line-done result is always the last one of its input.
    `DFS_ASSERT_IMP(a_done_last, aclk, aresetn, m_tvalid && m_tuser[2], m_tlast, "line done without last")
    // An open quote is only reported on the field end that closes the line.
    `DFS_ASSERT_IMP(a_unterm, aclk, aresetn, m_tvalid && m_tuser[3], m_tuser[1] && m_tuser[2], "unterminated quote outside line end")

endmodule

bind delimited_field_splitter_top dfs_checker u_dfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- verif/field_split_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited field splitter checker
// Watches the input, result and register channels. It tokenizes every
// accepted input transfer itself and compares each result transfer, field by
// field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module field_split_checker #(
    parameter int MAX_FIELDS = dfs_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [dfs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dfs_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [dfs_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            m_tlast,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [dfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dfs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending
);

    typedef enum logic [2:0] {
        SCAN_SKIP       = 3'd0,
        SCAN_AFTER_SOFT = 3'd1,
        SCAN_PLAIN      = 3'd2,
        SCAN_QUOTED     = 3'd3,
        SCAN_CLOSED     = 3'd4
    } scan_e;

    dfs_pkg::dfs_cfg_t    cfg;
    scan_e                scan;
    logic [7:0]           open_quote;
    int                   field_count;
    dfs_pkg::dfs_result_t expected_results[$];

    function automatic logic in_slots(input logic [63:0] slots, input int count,
                                      input logic [7:0] b);
        for (int i = 0; i < count; i++) begin
            if (slots[8*i +: 8] != 8'h00 && slots[8*i +: 8] == b)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void emit(input logic [7:0] b, input logic valid, input logic fend,
                                 input logic ldone, input logic unt, input logic miss);
        dfs_pkg::dfs_result_t r;
        r.out_byte           = b;
        r.byte_valid         = valid;
        r.field_end          = fend;
        r.field_index        = (field_count > dfs_pkg::INDEX_CAP)
                               ? dfs_pkg::FIELD_INDEX_W'(dfs_pkg::INDEX_CAP)
                               : dfs_pkg::FIELD_INDEX_W'(field_count);
        r.line_done          = ldone;
        r.unterminated_quote = unt;
        r.missing_delimiter  = miss;
        r.last               = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void close_field(input logic ldone, input logic unt, input logic miss);
        emit(8'h00, 1'b0, 1'b1, ldone, unt, miss);
        if (field_count < MAX_FIELDS - 1)
            field_count++;
    endfunction

    // The byte is known not to be a soft separator here.
    function automatic void open_field(input logic [7:0] b);
        if (in_slots({48'h0, cfg.quote_chars}, 2, b)) begin
            open_quote = b;
            scan       = SCAN_QUOTED;
        end else if (in_slots({32'h0, cfg.hard_set}, 4, b)) begin
            close_field(1'b0, 1'b0, 1'b0);
            scan = SCAN_SKIP;
        end else begin
            emit(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            scan = SCAN_PLAIN;
        end
    endfunction

    function automatic void tokenize_item(input logic [7:0] b, input logic eol);
        int   first;
        logic is_blank;
        logic is_hard;
        first    = expected_results.size();
        is_blank = in_slots(cfg.blank_set, 8, b);
        is_hard  = in_slots({32'h0, cfg.hard_set}, 4, b);
        if (eol) begin
            case (scan) inside
                SCAN_PLAIN, SCAN_CLOSED: close_field(1'b1, 1'b0, 1'b0);
                SCAN_QUOTED:             close_field(1'b1, 1'b1, 1'b0);
                default:                 emit(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
            endcase
            scan        = SCAN_SKIP;
            open_quote  = 8'h00;
            field_count = 0;
        end else begin
            case (scan)
                SCAN_AFTER_SOFT: begin
                    if (!is_blank) begin
                        if (is_hard)
                            scan = SCAN_SKIP;
                        else
                            open_field(b);
                    end
                end
                SCAN_PLAIN: begin
                    if (is_blank) begin
                        close_field(1'b0, 1'b0, 1'b0);
                        scan = SCAN_AFTER_SOFT;
                    end else if (is_hard) begin
                        close_field(1'b0, 1'b0, 1'b0);
                        scan = SCAN_SKIP;
                    end else begin
                        emit(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                    end
                end
                SCAN_QUOTED: begin
                    if (b == open_quote)
                        scan = SCAN_CLOSED;
                    else
                        emit(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                end
                SCAN_CLOSED: begin
                    // The byte after a closing quote decides how the field ends.
                    if (cfg.escape_en && b == open_quote) begin
                        emit(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                        scan = SCAN_QUOTED;
                    end else if (is_blank) begin
                        close_field(1'b0, 1'b0, 1'b0);
                        scan = SCAN_AFTER_SOFT;
                    end else if (is_hard) begin
                        close_field(1'b0, 1'b0, 1'b0);
                        scan = SCAN_SKIP;
                    end else begin
                        close_field(1'b0, 1'b0, 1'b1);
                        open_field(b);
                    end
                end
                default: begin
                    if (!is_blank)
                        open_field(b);
                    else
                        scan = SCAN_SKIP;
                end
            endcase
        end
        if (expected_results.size() > first)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void apply_write(input logic [dfs_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [dfs_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            dfs_pkg::REG_QUOTE_CHARS: cfg.quote_chars = data[15:0];
            dfs_pkg::REG_HARD_SET:    cfg.hard_set    = data[31:0];
            dfs_pkg::REG_BLANK_SET:   cfg.blank_set   = data;
            dfs_pkg::REG_ESCAPE_EN:   cfg.escape_en   = data[0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input int expv, input int gotv);
        if (expv != gotv) begin
            $error("%s: expected %0d, got %0d", name, expv, gotv);
            fail_count++;
        end
    endfunction

    function automatic void check_result(input logic [dfs_pkg::M_TDATA_W-1:0] tdata,
                                         input logic [dfs_pkg::M_TUSER_W-1:0] tuser,
                                         input logic tlast);
        dfs_pkg::dfs_result_t want;
        if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected: tdata %h tuser %h tlast %b",
                   tdata, tuser, tlast);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            check_field("out_byte", want.out_byte, tdata[7:0]);
            check_field("field_index", want.field_index, tdata[17:8]);
            check_field("byte_valid", want.byte_valid, tuser[0]);
            check_field("field_end", want.field_end, tuser[1]);
            check_field("line_done", want.line_done, tuser[2]);
            check_field("unterminated_quote", want.unterminated_quote, tuser[3]);
            check_field("missing_delimiter", want.missing_delimiter, tuser[4]);
            check_field("last", want.last, tlast);
        end
    endfunction

    // Results leave only after their input has passed the input register and the
    // result queue, so popping before pushing within one edge is safe.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg.quote_chars = dfs_pkg::QUOTE_CHARS_RESET;
            cfg.hard_set    = dfs_pkg::HARD_SET_RESET;
            cfg.blank_set   = dfs_pkg::BLANK_SET_RESET;
            cfg.escape_en   = dfs_pkg::ESCAPE_EN_RESET;
            scan            = SCAN_SKIP;
            open_quote      = 8'h00;
            field_count     = 0;
            expected_results.delete();
            fail_count      = 0;
            pending        <= 0;
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tuser, m_tlast);
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                tokenize_item(s_tdata, s_tlast);
            pending <= expected_results.size();
        end
    end

endmodule

// ----- verif/tb_delimited_field_splitter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited field splitter testbench
// Drives text lines through the splitter under several separator and quote
// settings: a short directed set, one line long enough to saturate the field
// index, then mostly well-formed random records mixed with noise. Both stream
// sides idle at random; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_delimited_field_splitter_top;

    localparam int MAX_FIELDS      = dfs_pkg::MAX_FIELDS_DEFAULT;
    localparam int PHASE_ITEMS     = 105;
    localparam int SATURATE_FIELDS = 1030;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 5000;

    // Receiver stall patterns.
    localparam int RX_READY  = 0;
    localparam int RX_LIGHT  = 1;
    localparam int RX_HEAVY  = 2;
    localparam int RX_BLOCKS = 3;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [dfs_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [dfs_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [dfs_pkg::M_TUSER_W-1:0]   m_tuser;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [dfs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dfs_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    int                fail_count;
    int                pending;
    int                items_sent  = 0;
    int                burst_left  = 0;
    int                idle_cycles = 0;
    int                rx_mode     = RX_READY;
    int                rx_left     = 0;
    dfs_pkg::dfs_cfg_t cur_cfg;

    delimited_field_splitter_top #(.MAX_FIELDS(MAX_FIELDS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    field_split_checker #(.MAX_FIELDS(MAX_FIELDS)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(RX_READY, RX_BLOCKS);
            rx_left <= $urandom_range(20, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_READY: m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_tready <= ($urandom_range(0, 9) < 3);
            default:  m_tready <= ((rx_left % 16) < 4);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic in_slots(input logic [63:0] slots, input int count,
                                      input logic [7:0] b);
        for (int i = 0; i < count; i++) begin
            if (slots[8*i +: 8] != 8'h00 && slots[8*i +: 8] == b)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Returns a random used slot, or zero when every slot is unused.
    function automatic logic [7:0] pick_slot(input logic [63:0] slots, input int count);
        logic [7:0] found[$];
        for (int i = 0; i < count; i++) begin
            if (slots[8*i +: 8] != 8'h00)
                found.push_back(slots[8*i +: 8]);
        end
        if (found.size() == 0)
            return 8'h00;
        return found[$urandom_range(0, found.size() - 1)];
    endfunction

    function automatic logic [7:0] pick_quote();
        return pick_slot({48'h0, cur_cfg.quote_chars}, 2);
    endfunction

    function automatic logic [7:0] pick_hard();
        return pick_slot({32'h0, cur_cfg.hard_set}, 4);
    endfunction

    function automatic logic [7:0] pick_soft();
        return pick_slot(cur_cfg.blank_set, 8);
    endfunction

    // Byte zero never matches a slot, so it is the fallback content byte.
    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        for (int i = 0; i < 8; i++) begin
            b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(8'h61, 8'h7A));
            if (!in_slots({48'h0, cur_cfg.quote_chars}, 2, b) &&
                !in_slots({32'h0, cur_cfg.hard_set}, 4, b) &&
                !in_slots(cur_cfg.blank_set, 8, b))
                return b;
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] pick_any();
        case ($urandom_range(0, 4))
            0:       return pick_quote();
            1:       return pick_hard();
            2:       return pick_soft();
            3:       return pick_plain();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pick_cfg_byte();
        case ($urandom_range(0, 10))
            0:       return 8'h00;
            1:       return 8'h2C;
            2:       return 8'h3B;
            3:       return 8'h7C;
            4:       return 8'h20;
            5:       return 8'h09;
            6:       return 8'h22;
            7:       return 8'h27;
            8:       return 8'h3A;
            9:       return 8'h23;
            default: return 8'h21;
        endcase
    endfunction

    function automatic dfs_pkg::dfs_cfg_t random_cfg();
        dfs_pkg::dfs_cfg_t c;
        for (int i = 0; i < 2; i++)
            c.quote_chars[8*i +: 8] = pick_cfg_byte();
        for (int i = 0; i < 4; i++)
            c.hard_set[8*i +: 8] = pick_cfg_byte();
        for (int i = 0; i < 8; i++)
            c.blank_set[8*i +: 8] = pick_cfg_byte();
        c.escape_en = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // The sender runs in bursts; a new burst may start after a gap.
    task automatic send_item(input logic [7:0] b, input logic eol);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_eol();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_item(txt[i], 1'b0);
    endtask

    // Stop sending until every predicted result has left the block.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [dfs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dfs_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Upper data bits carry junk that the register must drop. The last write
    // targets an index past the register list and must change nothing.
    task automatic program_cfg(input dfs_pkg::dfs_cfg_t c,
                               input logic [dfs_pkg::CFG_INDEX_W-1:0] stray_index);
        logic [dfs_pkg::CFG_DATA_W-1:0] data;
        drain_results();
        data = rand64();
        data[15:0] = c.quote_chars;
        write_reg(dfs_pkg::REG_QUOTE_CHARS, data);
        data = rand64();
        data[31:0] = c.hard_set;
        write_reg(dfs_pkg::REG_HARD_SET, data);
        write_reg(dfs_pkg::REG_BLANK_SET, c.blank_set);
        data = rand64();
        data[0] = c.escape_en;
        write_reg(dfs_pkg::REG_ESCAPE_EN, data);
        write_reg(stray_index, rand64());
        cfg_valid <= 1'b0;
        @(posedge aclk);
        cur_cfg = c;
    endtask

    task automatic send_soft_run();
        if (pick_soft() != 8'h00) begin
            repeat ($urandom_range(1, 3)) send_item(pick_soft(), 1'b0);
        end
    endtask

    task automatic send_plain_run();
        repeat ($urandom_range(1, 6)) send_item(pick_plain(), 1'b0);
    endtask

    // A quoted field; now and then it is left open to the end of the line, or
    // the closing quote is followed directly by a content byte.
    task automatic send_quoted(input logic [7:0] q, output logic hit_eol);
        logic [7:0] c;
        hit_eol = 1'b0;
        send_item(q, 1'b0);
        repeat ($urandom_range(0, 5)) begin
            if (cur_cfg.escape_en && $urandom_range(0, 4) == 0) begin
                send_item(q, 1'b0);
                send_item(q, 1'b0);
            end else begin
                c = pick_any();
                if (c == q)
                    c = pick_plain();
                send_item(c, 1'b0);
            end
        end
        if ($urandom_range(0, 11) == 0) begin
            send_eol();
            hit_eol = 1'b1;
        end else begin
            send_item(q, 1'b0);
            if ($urandom_range(0, 9) == 0)
                send_item(pick_plain(), 1'b0);
        end
    endtask

    task automatic send_record();
        int         nf;
        logic [7:0] h;
        logic [7:0] q;
        logic       hit_eol;
        nf = $urandom_range(0, 6);
        h  = 8'h00;
        if ($urandom_range(0, 2) == 0)
            send_soft_run();
        for (int i = 0; i < nf; i++) begin
            h = pick_hard();
            if (i > 0) begin
                if (h != 8'h00) begin
                    if ($urandom_range(0, 2) == 0)
                        send_soft_run();
                    send_item(h, 1'b0);
                    if ($urandom_range(0, 2) == 0)
                        send_soft_run();
                end else if (pick_soft() != 8'h00) begin
                    send_soft_run();
                end else begin
                    break;
                end
            end
            q = pick_quote();
            if (q != 8'h00 && $urandom_range(0, 2) == 0) begin
                send_quoted(q, hit_eol);
                if (hit_eol)
                    return;
            end else if (h == 8'h00 || i == 0 || $urandom_range(0, 7) != 0) begin
                send_plain_run();
            end
        end
        if ($urandom_range(0, 3) == 0)
            send_soft_run();
        h = pick_hard();
        if (h != 8'h00 && $urandom_range(0, 5) == 0)
            send_item(h, 1'b0);
        send_eol();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 9) == 0)
                send_eol();
            else
                send_item(pick_any(), 1'b0);
        end
    endtask

    task automatic run_phase();
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                send_record();
            else if (pick < 19)
                send_noise();
            else
                drain_results();
        end
    endtask

    initial begin
        dfs_pkg::dfs_cfg_t c;
        cur_cfg.quote_chars = dfs_pkg::QUOTE_CHARS_RESET;
        cur_cfg.hard_set    = dfs_pkg::HARD_SET_RESET;
        cur_cfg.blank_set   = dfs_pkg::BLANK_SET_RESET;
        cur_cfg.escape_en   = dfs_pkg::ESCAPE_EN_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty line, empty fields between hard separators, soft runs.
        send_eol();
        send_text(" ,,a b");
        send_eol();
        // Closing quotes followed by a quote and by content: missing delimiters.
        send_text("\"x\"\"y\"z");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_eol();
        // Quote still open at the end of the line.
        send_text("'q");
        send_eol();
        // A trailing hard separator opens no field.
        send_text("'a',");
        send_eol();

        // Enough empty fields to saturate the field index.
        repeat (SATURATE_FIELDS) send_item(dfs_pkg::HARD_SET_RESET[7:0], 1'b0);
        send_text("x");
        send_eol();
        run_phase();

        c = cur_cfg;
        c.escape_en = 1'b1;
        program_cfg(c, 8'($urandom_range(4, 254)));
        run_phase();

        c = '0;
        program_cfg(c, 8'hFF);
        run_phase();

        c = '1;
        program_cfg(c, 8'($urandom_range(4, 254)));
        run_phase();

        repeat (4) begin
            program_cfg(random_cfg(), 8'($urandom_range(4, 254)));
            run_phase();
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
